// ===== src/utli_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package utli_pkg;

    localparam int DEF_TABLE_DEPTH = 256;
    localparam int DEF_FRAC_BITS   = 16;

    // four 32-bit registers at byte addresses 0, 4, 8, 12
    localparam int APB_AW = 4;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_EVAL = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        REG_X_MIN      = 2'd0,
        REG_X_MAX      = 2'd1,
        REG_INV_STEP   = 2'd2,
        REG_TABLE_SIZE = 2'd3
    } t_reg_idx;

endpackage

`default_nettype wire

// ===== src/utli_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

module utli_table #(
    parameter  int DEPTH = utli_pkg::DEF_TABLE_DEPTH,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic signed [31:0]   i_wdata,
    input  logic [AW-1:0]        i_raddr_a,
    input  logic [AW-1:0]        i_raddr_b,
    output logic signed [31:0]   o_rdata_a,
    output logic signed [31:0]   o_rdata_b
);

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rdata_a;
    logic signed [31:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

// ===== src/uniform_table_linear_interp.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Direction | Transfer condition               | Payload
// ----------+-----------+----------------------------------+------------------------------
// command   | in        | start && !busy                   | action, entry_index,
//           |           |                                  | entry_value, sample_x
// result    | out       | o_done (one cycle, no back-off)  | value_y
// config    | in/out    | psel && penable && pwrite        | paddr, pwdata / prdata
//
// One item per clock; busy stays low. An evaluate transfer shows its result with
// o_done at the end of a seven-stage pipeline (clamp, offset, 32x32 scale multiply,
// dual-port table read, difference, blend multiply, final add). A load writes the
// table when it reaches the read stage, so later evaluates see it. Reset sets the
// config registers to defaults and clears pipeline valids, not the table.

module uniform_table_linear_interp #(
    parameter int TABLE_DEPTH = utli_pkg::DEF_TABLE_DEPTH,
    parameter int FRAC_BITS   = utli_pkg::DEF_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [utli_pkg::APB_AW-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          start,
    output logic                          busy,
    input  utli_pkg::t_action             i_action,
    input  logic [7:0]                    i_entry_index,
    input  logic signed [31:0]            i_entry_value,
    input  logic signed [31:0]            i_sample_x,
    output logic                          o_done,
    output logic signed [31:0]            o_value_y
);

    import utli_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NW = AW + 1;
    localparam int IW = 64 - 2 * FRAC_BITS;
    localparam int PW = 34 + FRAC_BITS;

    // ---------------- configuration ----------------
    logic signed [31:0] r_x_min;
    logic signed [31:0] r_x_max;
    logic [31:0]        r_inv_step;
    logic [8:0]         r_table_size;
    logic               w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_min      <= '0;
            r_x_max      <= '0;
            r_inv_step   <= 32'd65536;
            r_table_size <= 9'd256;
        end else if (w_cfg_wr) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_X_MIN:      r_x_min      <= pwdata;
                REG_X_MAX:      r_x_max      <= pwdata;
                REG_INV_STEP:   r_inv_step   <= pwdata;
                REG_TABLE_SIZE: r_table_size <= pwdata[8:0];
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_X_MIN:      prdata = r_x_min;
            REG_X_MAX:      prdata = r_x_max;
            REG_INV_STEP:   prdata = r_inv_step;
            REG_TABLE_SIZE: prdata = 32'(r_table_size);
        endcase
    end

    // size in use, saturated to [2, TABLE_DEPTH]
    logic [NW-1:0] w_n_act;

    always_comb begin
        if (r_table_size < 9'd2) begin
            w_n_act = NW'(2);
        end else if (32'(r_table_size) > TABLE_DEPTH) begin
            w_n_act = NW'(TABLE_DEPTH);
        end else begin
            w_n_act = NW'(r_table_size);
        end
    end

    // ---------------- stage 1: accept and clamp ----------------
    logic               w_accept;
    logic signed [31:0] w_x_c;

    assign busy     = 1'b0;
    assign w_accept = start & ~busy;

    always_comb begin
        w_x_c = i_sample_x;
        if (w_x_c > r_x_max) begin
            w_x_c = r_x_max;
        end
        if (w_x_c < r_x_min) begin
            w_x_c = r_x_min;
        end
    end

    logic               r1_valid, r2_valid, r3_valid, r4_valid;
    logic               r5_valid, r6_valid, r7_valid;
    t_action            r1_act, r2_act, r3_act;
    logic [7:0]         r1_idx, r2_idx, r3_idx;
    logic signed [31:0] r1_val, r2_val, r3_val;
    logic signed [31:0] r1_x;
    logic [31:0]        r2_d;
    logic [63:0]        r3_prod;
    logic               r4_last;
    logic [FRAC_BITS-1:0] r4_frac, r5_frac;
    logic signed [31:0] r5_yi, r6_yi;
    logic signed [32:0] r5_diff;
    logic signed [PW-1:0] r6_prod;
    logic signed [31:0] r7_y;

    // ---------------- stage 4 address generation ----------------
    logic [IW-1:0]        w_idx;
    logic [FRAC_BITS-1:0] w_frac;
    logic                 w_last;
    logic [AW-1:0]        w_addr_a;
    logic [AW-1:0]        w_addr_b;
    logic                 w_we;
    logic signed [31:0]   w_rd_a;
    logic signed [31:0]   w_rd_b;

    assign w_idx  = r3_prod[63:2*FRAC_BITS];
    assign w_frac = r3_prod[2*FRAC_BITS-1:FRAC_BITS];
    // upper neighbor past the end: return the last entry in use
    assign w_last = 64'(w_idx) >= (64'(w_n_act) - 64'd1);

    assign w_addr_a = w_last ? AW'(w_n_act - NW'(1)) : AW'(w_idx);
    assign w_addr_b = AW'(w_idx) + AW'(1);
    assign w_we     = r3_valid && (r3_act == ACT_LOAD) && (32'(r3_idx) < TABLE_DEPTH);

    utli_table #(
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (AW'(r3_idx)),
        .i_wdata   (r3_val),
        .i_raddr_a (w_addr_a),
        .i_raddr_b (w_addr_b),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    // ---------------- valid chain ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
            r7_valid <= 1'b0;
        end else begin
            r1_valid <= w_accept;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid && (r3_act == ACT_EVAL);
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
            r7_valid <= r6_valid;
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge i_clk) begin
        r1_act  <= i_action;
        r1_idx  <= i_entry_index;
        r1_val  <= i_entry_value;
        r1_x    <= w_x_c;

        r2_act  <= r1_act;
        r2_idx  <= r1_idx;
        r2_val  <= r1_val;
        r2_d    <= 32'(r1_x - r_x_min);     // x >= x_min, so fits unsigned

        r3_act  <= r2_act;
        r3_idx  <= r2_idx;
        r3_val  <= r2_val;
        r3_prod <= 64'(r2_d) * 64'(r_inv_step);

        r4_last <= w_last;
        r4_frac <= w_frac;

        // y = yi + floor(f * (yj - yi) / 2^F); zero slope at the end
        r5_yi   <= w_rd_a;
        r5_diff <= r4_last ? 33'sd0 : (33'(w_rd_b) - 33'(w_rd_a));
        r5_frac <= r4_frac;

        r6_yi   <= r5_yi;
        r6_prod <= r5_diff * $signed({1'b0, r5_frac});

        r7_y    <= r6_yi + r6_prod[FRAC_BITS+31:FRAC_BITS];
    end

    assign o_done    = r7_valid;
    assign o_value_y = r7_y;

    // ---------------- assertions ----------------
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_action == ACT_EVAL) |-> ##7 o_done)
        else $error("evaluate transfer produced no result");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_action == ACT_LOAD) |-> ##7 !o_done)
        else $error("load transfer produced a result");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy && i_action == ACT_EVAL, 7))
        else $error("result without a matching evaluate");

endmodule

`default_nettype wire
